// ===== hw/rtl/pidpv_pkg.sv =====
package pidpv_pkg;

  // Width of every word on the data channels and of the configuration data.
  localparam int WORD_W = 32;
  // Width of the configuration register index.
  localparam int IDX_W = 4;
  // Magnitude bits taken from the multiplier operand; every operand stays below 2^35.
  localparam int MUL_B_W = 36;
  // Magnitude bits kept from the multiplicand; every multiplicand stays within 2^60.
  localparam int MUL_A_W = 62;
  // Product and quotient magnitude limit is 2^60.
  localparam int TERM_LIM_BIT = 60;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN   = 4'd0,
    REG_INTEG_GAIN  = 4'd1,
    REG_DERIV_GAIN  = 4'd2,
    REG_SETPOINT    = 4'd3,
    REG_TICK_PERIOD = 4'd4,
    REG_DRIVE_MIN   = 4'd5,
    REG_DRIVE_MAX   = 4'd6,
    REG_FLAGS       = 4'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I1,
    S_MUL_I2,
    S_MUL_D,
    S_DIV_D,
    S_SUM,
    S_DIV_AW,
    S_DONE
  } state_t;

  // Request to a serial arithmetic unit.
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } op_req_t;

  // Response of a serial arithmetic unit; result is valid while done is high.
  typedef struct packed {
    logic               done;
    logic signed [63:0] result;
  } op_rsp_t;

endpackage

// ===== hw/rtl/pidpv_if.sv =====
interface pidpv_meas_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pidpv_pkg::WORD_W-1:0]     measurement;
  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

interface pidpv_drive_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pidpv_pkg::WORD_W-1:0]     drive;
  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

interface pidpv_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [pidpv_pkg::IDX_W-1:0]             index;
  logic [pidpv_pkg::WORD_W-1:0]            data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/pidpv_mul.sv =====
module pidpv_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  pidpv_pkg::op_req_t req,
  output pidpv_pkg::op_rsp_t rsp
);

  localparam int AW = pidpv_pkg::MUL_A_W;
  localparam int BW = pidpv_pkg::MUL_B_W;
  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW);
  localparam logic [PW-1:0] LIM = PW'(1) << pidpv_pkg::TERM_LIM_BIT;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [AW-1:0] ma;
  logic [PW-1:0] prod;
  logic [63:0]   abs_a;
  logic [63:0]   abs_b;
  logic [AW:0]   sum;
  logic [PW-1:0] shifted;
  logic [63:0]   mag;

  assign abs_a = req.a[63] ? 64'(-req.a) : 64'(req.a);
  assign abs_b = req.b[63] ? 64'(-req.b) : 64'(req.b);

  // Shift-add: one multiplier bit per cycle, partial product in the upper AW bits.
  assign sum = {1'b0, prod[PW-1:BW]} + (prod[0] ? {1'b0, ma} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.a[63] ^ req.b[63];
        ma   <= abs_a[AW-1:0];
        prod <= {{AW{1'b0}}, abs_b[BW-1:0]};
      end else if (busy) begin
        prod <= {sum, prod[BW-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign shifted = prod >> FRAC_BITS;
  assign mag = (shifted > LIM) ? 64'(LIM) : 64'(shifted);

  assign rsp.done   = done;
  assign rsp.result = neg ? -$signed(mag) : $signed(mag);

endmodule

// ===== hw/rtl/pidpv_div.sv =====
module pidpv_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  pidpv_pkg::op_req_t req,
  output pidpv_pkg::op_rsp_t rsp
);

  localparam int DW = 64 + FRAC_BITS;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] LIM = DW'(1) << pidpv_pkg::TERM_LIM_BIT;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [DW-1:0] quo;
  logic [32:0]   rem;
  logic [31:0]   dv;
  logic [63:0]   abs_a;
  logic [63:0]   abs_b;
  logic [33:0]   trial;
  logic          fits;
  logic [63:0]   mag;

  assign abs_a = req.a[63] ? 64'(-req.a) : 64'(req.a);
  assign abs_b = req.b[63] ? 64'(-req.b) : 64'(req.b);

  // Restoring division, one quotient bit per cycle; dividend bits shift out of quo.
  assign trial = {rem, quo[DW-1]};
  assign fits  = trial >= {2'b00, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.a[63] ^ req.b[63];
        quo  <= {abs_a, {FRAC_BITS{1'b0}}};
        rem  <= '0;
        dv   <= abs_b[31:0];
      end else if (busy) begin
        rem  <= fits ? 33'(trial - {2'b00, dv}) : trial[32:0];
        quo  <= {quo[DW-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign mag = (quo > LIM) ? 64'(LIM) : 64'(quo);

  assign rsp.done   = done;
  assign rsp.result = neg ? -$signed(mag) : $signed(mag);

endmodule

// ===== hw/rtl/pid_positional_velocity_top.sv =====
// PID controller in positional or velocity form on signed fixed-point words with
// FRAC_BITS fraction bits. Each measurement word taken on meas yields one drive word
// on drv, clamped to the configured limits. The arithmetic runs on one bit-serial
// multiplier and one bit-serial restoring divider, used in turn by a sequencer, so
// one word takes four products and one quotient, and one more quotient when
// positional anti-windup is active with a nonzero integral gain. A new measurement
// is taken once the previous drive word sits in the output register, while that
// word still waits to be taken.
// Configuration writes are always accepted and must be issued while the block is
// idle; a write to the flags register clears the controller history.
module pid_positional_velocity_top #(
  parameter int FRAC_BITS = 16
) (
  input logic                clk,
  input logic                rst,
  pidpv_meas_if.sink         meas,
  pidpv_drive_if.source      drv,
  pidpv_cfg_if.sink          cfg
);

  localparam logic signed [63:0] INTEG_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] INTEG_MIN = -64'sd140737488355328;

  pidpv_pkg::state_t state;
  pidpv_pkg::state_t state_next;

  // Configuration registers.
  logic signed [31:0] prop_gain;
  logic signed [31:0] integ_gain;
  logic signed [31:0] deriv_gain;
  logic signed [31:0] setpoint;
  logic        [31:0] tick_period;
  logic signed [31:0] drive_min;
  logic signed [31:0] drive_max;
  logic        [2:0]  control_flags;

  // Controller history.
  logic signed [47:0] error_integral;
  logic signed [32:0] last_error;
  logic signed [32:0] older_error;
  logic signed [31:0] last_measure;
  logic signed [31:0] older_measure;
  logic signed [31:0] last_drive;

  // Working registers of the current word.
  logic signed [31:0] meas_q;
  logic signed [32:0] err;
  logic signed [63:0] p_term;
  logic signed [63:0] i_term;
  logic signed [63:0] d_term;
  logic signed [63:0] tmp;
  logic signed [63:0] pre;
  logic signed [31:0] drive_q;
  logic               launched;
  logic               out_valid;
  logic signed [31:0] out_word;

  pidpv_pkg::op_req_t mul_req;
  pidpv_pkg::op_rsp_t mul_rsp;
  pidpv_pkg::op_req_t div_req;
  pidpv_pkg::op_rsp_t div_rsp;

  logic               velocity;
  logic               anti_windup;
  logic               on_meas;
  logic               in_take;
  logic               out_free;
  logic signed [32:0] err_in;
  logic signed [63:0] diff;
  logic signed [63:0] sum_all;
  logic               op_done;

  assign velocity    = control_flags[0];
  assign anti_windup = control_flags[1];
  assign on_meas     = control_flags[2];

  assign meas.ready = (state == pidpv_pkg::S_IDLE);
  assign in_take    = meas.valid && meas.ready;
  assign cfg.ready  = 1'b1;
  assign out_free   = !out_valid || drv.ready;

  assign drv.valid = out_valid;
  assign drv.drive = out_word;

  assign err_in = 33'(setpoint) - 33'(meas.measurement);

  pidpv_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  pidpv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  function automatic logic signed [63:0] sat48(input logic signed [63:0] v);
    if (v > INTEG_MAX) begin
      return INTEG_MAX;
    end
    if (v < INTEG_MIN) begin
      return INTEG_MIN;
    end
    return v;
  endfunction

  // Crossed limits: values above the upper limit give it, all others the lower limit.
  function automatic logic signed [31:0] clamp_drive(input logic signed [63:0] v,
                                                     input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi);
    if (v > 64'(hi)) begin
      return hi;
    end
    if (v < 64'(lo)) begin
      return lo;
    end
    return v[31:0];
  endfunction

  // Derivative input: first difference in positional form, second difference in
  // velocity form, taken on the error or on the negated measurement.
  always_comb begin
    if (velocity) begin
      if (on_meas) begin
        diff = 64'(last_measure) + 64'(last_measure) - 64'(meas_q) - 64'(older_measure);
      end else begin
        diff = 64'(err) - 64'(last_error) - 64'(last_error) + 64'(older_error);
      end
    end else begin
      if (on_meas) begin
        diff = 64'(last_measure) - 64'(meas_q);
      end else begin
        diff = 64'(err) - 64'(last_error);
      end
    end
  end

  assign sum_all = p_term + i_term + d_term + (velocity ? 64'(last_drive) : 64'sd0);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pidpv_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = pidpv_pkg::S_MUL_P;
        end
      end
      pidpv_pkg::S_MUL_P: begin
        if (mul_rsp.done) begin
          state_next = pidpv_pkg::S_MUL_I1;
        end
      end
      pidpv_pkg::S_MUL_I1: begin
        if (mul_rsp.done) begin
          state_next = pidpv_pkg::S_MUL_I2;
        end
      end
      pidpv_pkg::S_MUL_I2: begin
        if (mul_rsp.done) begin
          state_next = pidpv_pkg::S_MUL_D;
        end
      end
      pidpv_pkg::S_MUL_D: begin
        if (mul_rsp.done) begin
          state_next = pidpv_pkg::S_DIV_D;
        end
      end
      pidpv_pkg::S_DIV_D: begin
        if (div_rsp.done) begin
          state_next = pidpv_pkg::S_SUM;
        end
      end
      pidpv_pkg::S_SUM: begin
        if (!velocity && anti_windup && integ_gain != 32'sd0) begin
          state_next = pidpv_pkg::S_DIV_AW;
        end else begin
          state_next = pidpv_pkg::S_DONE;
        end
      end
      pidpv_pkg::S_DIV_AW: begin
        if (div_rsp.done) begin
          state_next = pidpv_pkg::S_DONE;
        end
      end
      pidpv_pkg::S_DONE: begin
        if (out_free) begin
          state_next = pidpv_pkg::S_IDLE;
        end
      end
      default: state_next = pidpv_pkg::S_IDLE;
    endcase
  end

  // Operand selection and unit start pulses.
  always_comb begin
    mul_req       = '0;
    div_req       = '0;
    case (state)
      pidpv_pkg::S_MUL_P: begin
        mul_req.a = 64'(prop_gain);
        mul_req.b = velocity ? 64'(err) - 64'(last_error) : 64'(err);
        mul_req.start = !launched;
      end
      pidpv_pkg::S_MUL_I1: begin
        mul_req.a = velocity ? 64'(integ_gain) : 64'(err);
        mul_req.b = velocity ? 64'(err) : $signed({32'd0, tick_period});
        mul_req.start = !launched;
      end
      pidpv_pkg::S_MUL_I2: begin
        mul_req.a = velocity ? tmp : 64'(error_integral);
        mul_req.b = velocity ? $signed({32'd0, tick_period}) : 64'(integ_gain);
        mul_req.start = !launched;
      end
      pidpv_pkg::S_MUL_D: begin
        mul_req.a = 64'(deriv_gain);
        mul_req.b = diff;
        mul_req.start = !launched;
      end
      pidpv_pkg::S_DIV_D: begin
        div_req.a = tmp;
        div_req.b = $signed({32'd0, tick_period});
        div_req.start = !launched;
      end
      pidpv_pkg::S_DIV_AW: begin
        div_req.a = 64'(drive_q) - pre;
        div_req.b = 64'(integ_gain);
        div_req.start = !launched;
      end
      default: begin
        mul_req = '0;
        div_req = '0;
      end
    endcase
  end

  assign op_done = mul_rsp.done || div_rsp.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pidpv_pkg::S_IDLE;
      launched       <= 1'b0;
      out_valid      <= 1'b0;
      prop_gain      <= '0;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      setpoint       <= '0;
      tick_period    <= 32'(1) << FRAC_BITS;
      drive_min      <= 32'sh8000_0000;
      drive_max      <= 32'sh7FFF_FFFF;
      control_flags  <= '0;
      error_integral <= '0;
      last_error     <= '0;
      older_error    <= '0;
      last_measure   <= '0;
      older_measure  <= '0;
      last_drive     <= '0;
    end else begin
      state <= state_next;

      if (mul_req.start || div_req.start) begin
        launched <= 1'b1;
      end else if (op_done) begin
        launched <= 1'b0;
      end

      if (cfg.valid) begin
        case (pidpv_pkg::cfg_reg_t'(cfg.index))
          pidpv_pkg::REG_PROP_GAIN:  prop_gain  <= cfg.data;
          pidpv_pkg::REG_INTEG_GAIN: integ_gain <= cfg.data;
          pidpv_pkg::REG_DERIV_GAIN: deriv_gain <= cfg.data;
          pidpv_pkg::REG_SETPOINT:   setpoint   <= cfg.data;
          pidpv_pkg::REG_TICK_PERIOD: begin
            // A zero period is ignored.
            if (cfg.data != '0) begin
              tick_period <= cfg.data;
            end
          end
          pidpv_pkg::REG_DRIVE_MIN:  drive_min  <= cfg.data;
          pidpv_pkg::REG_DRIVE_MAX:  drive_max  <= cfg.data;
          pidpv_pkg::REG_FLAGS: begin
            control_flags  <= cfg.data[2:0];
            error_integral <= '0;
            last_error     <= '0;
            older_error    <= '0;
            last_measure   <= '0;
            older_measure  <= '0;
            last_drive     <= '0;
          end
          default: begin
          end
        endcase
      end

      if (in_take) begin
        meas_q <= meas.measurement;
        err    <= err_in;
      end

      case (state)
        pidpv_pkg::S_MUL_P: begin
          if (mul_rsp.done) begin
            p_term <= mul_rsp.result;
          end
        end
        pidpv_pkg::S_MUL_I1: begin
          if (mul_rsp.done) begin
            if (velocity) begin
              tmp <= mul_rsp.result;
            end else begin
              error_integral <= 48'(sat48(64'(error_integral) + mul_rsp.result));
            end
          end
        end
        pidpv_pkg::S_MUL_I2: begin
          if (mul_rsp.done) begin
            i_term <= mul_rsp.result;
          end
        end
        pidpv_pkg::S_MUL_D: begin
          if (mul_rsp.done) begin
            tmp <= mul_rsp.result;
          end
        end
        pidpv_pkg::S_DIV_D: begin
          if (div_rsp.done) begin
            d_term <= div_rsp.result;
          end
        end
        pidpv_pkg::S_SUM: begin
          pre     <= sum_all;
          drive_q <= clamp_drive(sum_all, drive_min, drive_max);
        end
        pidpv_pkg::S_DIV_AW: begin
          if (div_rsp.done) begin
            error_integral <= 48'(sat48(64'(error_integral) + div_rsp.result));
          end
        end
        pidpv_pkg::S_DONE: begin
          if (out_free) begin
            older_error   <= last_error;
            last_error    <= err;
            older_measure <= last_measure;
            last_measure  <= meas_q;
            last_drive    <= drive_q;
            out_word      <= drive_q;
          end
        end
        default: begin
        end
      endcase

      // The output register fills when a word completes and empties when taken.
      if (state == pidpv_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (drv.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
